// ===== hw/rtl/bth_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, status codes and datapath command codes for the top-N heap.
// No dependencies; every other file of the block but bth_ram imports this package.
package bth_pkg;

   localparam int HEAP_DEPTH_DEF = 64;

   localparam int SCORE_W  = 16;
   localparam int LEN_W    = 32;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 3;
   localparam int CAP_W    = 7;
   localparam int OCC_W    = 7;
   localparam int ENTRY_W  = SCORE_W + LEN_W + ID_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   // datapath commands
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
   localparam logic [OP_W-1:0] OP_UP_START   = 4'd2;
   localparam logic [OP_W-1:0] OP_ROOT_READ  = 4'd3;
   localparam logic [OP_W-1:0] OP_EMPTY      = 4'd4;
   localparam logic [OP_W-1:0] OP_POP_READ   = 4'd5;
   localparam logic [OP_W-1:0] OP_UP_STEP    = 4'd6;
   localparam logic [OP_W-1:0] OP_ROOT_CHECK = 4'd7;
   localparam logic [OP_W-1:0] OP_POP_TAKE   = 4'd8;
   localparam logic [OP_W-1:0] OP_DOWN_STEP  = 4'd9;
   localparam logic [OP_W-1:0] OP_WRITE_X    = 4'd10;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [LEN_W-1:0]   length;
      logic [ID_W-1:0]    id;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic has_room;
      logic fill_zero;
      logic fill_one;
      logic fill_gt2;
      logic root_more;
      logic up_move;
      logic parent_zero;
      logic root_worse;
      logic down_move;
      logic down_more;
   } stat_type;

   // true if a ranks strictly worse than b
   function automatic logic worse(entry_type a, entry_type b);
      logic r;
      if (a.score != b.score) begin
         r = (a.score < b.score);
      end else if (a.length != b.length) begin
         r = (a.length > b.length);
      end else begin
         r = (a.id > b.id);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/bth_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the top-N heap: request, response and capacity write.
// Payload widths come from bth_pkg.
interface bth_req_if import bth_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [SCORE_W-1:0] score;
   logic [LEN_W-1:0]   seq_length;
   logic [ID_W-1:0]    seq_id;

   modport source (output valid, req_type, score, seq_length, seq_id, input ready);
   modport sink   (input valid, req_type, score, seq_length, seq_id, output ready);
endinterface

interface bth_rsp_if import bth_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SCORE_W-1:0]  out_score;
   logic [LEN_W-1:0]    out_length;
   logic [ID_W-1:0]     out_id;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_score, out_length, out_id, occupancy,
                   input ready);
   modport sink   (input valid, status, out_score, out_length, out_id, occupancy,
                   output ready);
endinterface

interface bth_csr_if import bth_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/bth_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// Standalone; no package needed.
module bth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd0_addr,
   output logic [WIDTH-1:0]         rd0_data,
   input  logic [$clog2(DEPTH)-1:0] rd1_addr,
   output logic [WIDTH-1:0]         rd1_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd0_ff <= mem_ff[rd0_addr];
      rd1_ff <= mem_ff[rd1_addr];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

// ===== hw/rtl/bth_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the top-N heap: steps one word through dispatch, sift and result.
// Depends on bth_pkg for command codes and the status struct.
module bth_ctrl import bth_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_UP       = 3'd2;
   localparam logic [2:0] S_ROOT     = 3'd3;
   localparam logic [2:0] S_POP      = 3'd4;
   localparam logic [2:0] S_DOWN     = 3'd5;
   localparam logic [2:0] S_WRITE    = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.is_pop) begin
               if (stat.has_room) begin
                  cmd.op   = OP_UP_START;
                  state_in = stat.fill_zero ? S_WRITE : S_UP;
               end else begin
                  cmd.op   = OP_ROOT_READ;
                  state_in = S_ROOT;
               end
            end else if (stat.fill_zero) begin
               cmd.op   = OP_EMPTY;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_POP_READ;
               state_in = S_POP;
            end
         end
         S_UP: begin
            cmd.op = OP_UP_STEP;
            if (!stat.up_move || stat.parent_zero) begin
               state_in = S_WRITE;
            end
         end
         S_ROOT: begin
            cmd.op = OP_ROOT_CHECK;
            if (!stat.root_worse) begin
               state_in = S_RESP;
            end else begin
               state_in = stat.root_more ? S_DOWN : S_WRITE;
            end
         end
         S_POP: begin
            cmd.op = OP_POP_TAKE;
            if (stat.fill_one) begin
               state_in = S_RESP;
            end else begin
               state_in = stat.fill_gt2 ? S_DOWN : S_WRITE;
            end
         end
         S_DOWN: begin
            cmd.op = OP_DOWN_STEP;
            if (!stat.down_move || !stat.down_more) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE_X;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               // take the next word in the same cycle the result leaves
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.op   = OP_ACCEPT;
                  state_in = S_DISPATCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/bth_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the top-N heap: heap RAM, fill count, capacity, sift registers, result.
// Depends on bth_pkg and bth_ram.
module bth_dpath import bth_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                req_type,
   input  logic [SCORE_W-1:0]  score,
   input  logic [LEN_W-1:0]    seq_length,
   input  logic [ID_W-1:0]     seq_id,
   input  logic                cap_wr,
   input  logic [CAP_W-1:0]    cap_data,
   output logic [STATUS_W-1:0] status,
   output logic [SCORE_W-1:0]  out_score,
   output logic [LEN_W-1:0]    out_length,
   output logic [ID_W-1:0]     out_id,
   output logic [OCC_W-1:0]    occupancy
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int FW = AW + 1;
   localparam int EW = (FW > CAP_W) ? FW : CAP_W;

   logic [CAP_W-1:0]    cap_ff;
   logic [FW-1:0]       fill_ff, fill_in;
   logic                pop_ff, pop_in;
   entry_type           x_ff, x_in;
   logic [AW-1:0]       hole_ff, hole_in;
   logic [FW-1:0]       child_ff, child_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   entry_type           out_ff, out_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_data;
   logic [AW-1:0]      rd0_addr, rd1_addr;
   logic [ENTRY_W-1:0] rd0_raw, rd1_raw;
   entry_type          rd0_e, rd1_e;

   logic [EW-1:0] cap_w, eff_cap;
   logic [FW-1:0] fill_m1;
   logic [AW-1:0] par_fill, par_hole, par_par;
   logic [FW-1:0] child1, c_idx, n2, n2p1;
   logic          sel1;
   entry_type     c_e;

   bth_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (rd0_addr),
      .rd0_data (rd0_raw),
      .rd1_addr (rd1_addr),
      .rd1_data (rd1_raw)
   );

   assign rd0_e = entry_type'(rd0_raw);
   assign rd1_e = entry_type'(rd1_raw);

   // zero acts as one, above the RAM depth saturates
   always_comb begin
      cap_w = EW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (cap_w > EW'(HEAP_DEPTH)) begin
         eff_cap = EW'(HEAP_DEPTH);
      end else begin
         eff_cap = cap_w;
      end
   end

   assign fill_m1  = fill_ff - FW'(1);
   assign par_fill = (fill_ff[AW-1:0] - AW'(1)) >> 1;
   assign par_hole = (hole_ff - AW'(1)) >> 1;
   assign par_par  = (par_hole - AW'(1)) >> 1;

   // pick the worse child; the right one counts only inside the heap
   assign child1 = child_ff + FW'(1);
   assign sel1   = (child1 < fill_ff) && worse(rd1_e, rd0_e);
   assign c_idx  = sel1 ? child1 : child_ff;
   assign c_e    = sel1 ? rd1_e : rd0_e;
   assign n2     = {c_idx[AW-1:0], 1'b1};
   assign n2p1   = n2 + FW'(1);

   always_comb begin
      stat.is_pop      = pop_ff;
      stat.has_room    = (EW'(fill_ff) < eff_cap) && (fill_ff < FW'(HEAP_DEPTH));
      stat.fill_zero   = (fill_ff == '0);
      stat.fill_one    = (fill_ff == FW'(1));
      stat.fill_gt2    = (fill_ff > FW'(2));
      stat.root_more   = (fill_ff > FW'(1));
      stat.up_move     = worse(x_ff, rd0_e);
      stat.parent_zero = (par_hole == '0);
      stat.root_worse  = worse(rd0_e, x_ff);
      stat.down_move   = worse(c_e, x_ff);
      stat.down_more   = (n2 < fill_ff);
   end

   always_comb begin
      fill_in   = fill_ff;
      pop_in    = pop_ff;
      x_in      = x_ff;
      hole_in   = hole_ff;
      child_in  = child_ff;
      status_in = status_ff;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_addr   = hole_ff;
      wr_data   = x_ff;
      rd0_addr  = '0;
      rd1_addr  = '0;
      case (cmd.op)
         OP_ACCEPT: begin
            pop_in = req_type;
            x_in   = '{score: score, length: seq_length, id: seq_id};
            out_in = '0;
         end
         OP_UP_START: begin
            hole_in   = fill_ff[AW-1:0];
            fill_in   = fill_ff + FW'(1);
            status_in = ST_INSERTED;
            rd0_addr  = par_fill;
         end
         OP_ROOT_READ: begin
            rd0_addr = '0;
         end
         OP_EMPTY: begin
            status_in = ST_EMPTY;
         end
         OP_POP_READ: begin
            rd0_addr = '0;
            rd1_addr = fill_m1[AW-1:0];
         end
         OP_UP_STEP: begin
            if (stat.up_move) begin
               // pull the parent down into the hole and climb
               wr_en    = 1'b1;
               wr_data  = rd0_e;
               hole_in  = par_hole;
               rd0_addr = par_par;
            end
         end
         OP_ROOT_CHECK: begin
            if (stat.root_worse) begin
               status_in = ST_REPLACED;
               hole_in   = '0;
               child_in  = FW'(1);
               rd0_addr  = AW'(1);
               rd1_addr  = AW'(2);
            end else begin
               status_in = ST_REJECTED;
            end
         end
         OP_POP_TAKE: begin
            out_in    = rd0_e;
            x_in      = rd1_e;
            fill_in   = fill_m1;
            status_in = ST_POPPED;
            hole_in   = '0;
            child_in  = FW'(1);
            rd0_addr  = AW'(1);
            rd1_addr  = AW'(2);
         end
         OP_DOWN_STEP: begin
            if (stat.down_move) begin
               // lift the worse child into the hole and descend
               wr_en    = 1'b1;
               wr_data  = c_e;
               hole_in  = c_idx[AW-1:0];
               child_in = n2;
               rd0_addr = n2[AW-1:0];
               rd1_addr = n2p1[AW-1:0];
            end
         end
         OP_WRITE_X: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         fill_ff <= '0;
      end else begin
         if (cap_wr) begin
            cap_ff <= cap_data;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_ff    <= pop_in;
      x_ff      <= x_in;
      hole_ff   <= hole_in;
      child_ff  <= child_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign status     = status_ff;
   assign out_score  = out_ff.score;
   assign out_length = out_ff.length;
   assign out_id     = out_ff.id;
   assign occupancy  = OCC_W'(fill_ff);

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(HEAP_DEPTH))
      else $error("fill count above heap depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (FW'(wr_addr) < fill_ff))
      else $error("heap write outside held entries");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_POP_TAKE) |-> (fill_ff != '0))
      else $error("pop taken from empty heap");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_UP_START) |-> (fill_ff < FW'(HEAP_DEPTH)))
      else $error("insert into full heap memory");
`endif

endmodule

// ===== hw/rtl/bounded_top_n_min_heap_top.sv =====
`timescale 1ns / 1ps
// Top-N min-heap: keeps the best candidates, root is the worst one held.
// From request word to result word: an add into a free slot may sift up, and a replace
// or a pop may sift down, one level a cycle over at most log2 HEAP_DEPTH heap levels;
// a rejected add, a pop of the one entry and a pop of the empty heap do not sift.
// A new request word is taken in the cycle its predecessor's result word is taken.
// Synchronous reset empties the heap and sets capacity to 64; heap RAM is not cleared.
module bounded_top_n_min_heap_top import bth_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   bth_req_if.sink   req_ch,
   bth_rsp_if.source rsp_ch,
   bth_csr_if.sink   csr_ch
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;
   logic     rsp_valid;

   bth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bth_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_ch.req_type),
      .score      (req_ch.score),
      .seq_length (req_ch.seq_length),
      .seq_id     (req_ch.seq_id),
      .cap_wr     (csr_ch.valid),
      .cap_data   (csr_ch.data),
      .status     (rsp_ch.status),
      .out_score  (rsp_ch.out_score),
      .out_length (rsp_ch.out_length),
      .out_id     (rsp_ch.out_id),
      .occupancy  (rsp_ch.occupancy)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

endmodule
